// File: rtl/mwm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mwm_pkg;

    // fixed-point format: 1.0 = 2**FRAC_BITS
    localparam int FRAC_BITS  = 13;
    localparam int IN_W       = 16;
    localparam int OUT_W      = 15;
    localparam int LANES      = 4;

    // sums of three inputs need two extra bits
    localparam int SUM_W      = IN_W + 2;
    localparam int MAG_W      = SUM_W - 1;
    localparam int REM_W      = SUM_W;
    // quotient never exceeds 1.0, so one integer bit
    localparam int Q_W        = FRAC_BITS + 1;
    localparam int DIV_STAGES = Q_W;
    localparam int VAL_W      = (SUM_W > Q_W + 1) ? SUM_W : Q_W + 1;

    localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

    // wheel lanes
    localparam int LANE_FL = 0;
    localparam int LANE_FR = 1;
    localparam int LANE_RL = 2;
    localparam int LANE_RR = 3;

    localparam int IN_TDATA_W  = ((3 * IN_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((LANES * OUT_W + 7) / 8) * 8;

    typedef logic [LANES-1:0][SUM_W-1:0] sum_vec_t;
    typedef logic [LANES-1:0][MAG_W-1:0] mag_vec_t;
    typedef logic [LANES-1:0][REM_W-1:0] rem_vec_t;
    typedef logic [LANES-1:0][Q_W-1:0]   quo_vec_t;

    // data that rides alongside the divider
    typedef struct packed {
        logic [LANES-1:0] neg;
        logic             scale;
        sum_vec_t         wheel;
    } side_t;

    typedef struct packed {
        logic             bit_q;
        logic [REM_W-1:0] rem;
    } div_res_t;

    // one restoring step: shift (except on the first step), compare, subtract
    function automatic div_res_t div_step(input logic [REM_W-1:0] r,
                                          input logic [MAG_W-1:0] d,
                                          input logic             first);
        logic [REM_W-1:0] shifted;
        logic [REM_W-1:0] d_ext;
        div_res_t         res;
        shifted   = first ? r : {r[REM_W-2:0], 1'b0};
        d_ext     = REM_W'(d);
        res.bit_q = (shifted >= d_ext);
        res.rem   = res.bit_q ? shifted - d_ext : shifted;
        return res;
    endfunction

endpackage

`default_nettype wire

// File: rtl/mwm_divider.sv
`timescale 1ns / 1ps
`default_nettype none

// four-lane restoring divider sharing one divisor, one quotient bit per stage
module mwm_divider
    import mwm_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire logic [MAG_W-1:0] in_divisor,
    input  wire mag_vec_t         in_dividend,
    input  wire side_t            in_side,
    output logic                  out_valid,
    output quo_vec_t              out_quo,
    output side_t                 out_side
);

    rem_vec_t         rem_reg  [DIV_STAGES];
    rem_vec_t         rem_next [DIV_STAGES];
    quo_vec_t         quo_reg  [DIV_STAGES];
    quo_vec_t         quo_next [DIV_STAGES];
    logic [MAG_W-1:0] div_reg  [DIV_STAGES];
    side_t            side_reg [DIV_STAGES];
    logic [DIV_STAGES-1:0] valid_reg;

    always_comb begin
        div_res_t res;
        for (int k = 0; k < DIV_STAGES; k++) begin
            for (int i = 0; i < LANES; i++) begin
                if (k == 0) begin
                    res = div_step(REM_W'(in_dividend[i]), in_divisor, 1'b1);
                    quo_next[k][i] = Q_W'(res.bit_q);
                end else begin
                    res = div_step(rem_reg[k-1][i], div_reg[k-1], 1'b0);
                    quo_next[k][i] = {quo_reg[k-1][i][Q_W-2:0], res.bit_q};
                end
                rem_next[k][i] = res.rem;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[DIV_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                rem_reg[k] <= rem_next[k];
                quo_reg[k] <= quo_next[k];
                if (k == 0) begin
                    div_reg[k]  <= in_divisor;
                    side_reg[k] <= in_side;
                end else begin
                    div_reg[k]  <= div_reg[k-1];
                    side_reg[k] <= side_reg[k-1];
                end
            end
        end
    end

    assign out_valid = valid_reg[DIV_STAGES-1];
    assign out_quo   = quo_reg[DIV_STAGES-1];
    assign out_side  = side_reg[DIV_STAGES-1];

endmodule

`default_nettype wire

// File: rtl/mecanum_wheel_mixer_top.sv
`timescale 1ns / 1ps
`default_nettype none

// mecanum wheel mixer: takes forward, turn and strafe speeds (signed, 1.0 = 2**FRAC_BITS)
// and gives four wheel speeds fl = v-w+s, fr = v+w-s, rl = v-w-s, rr = v+w+s. when the
// largest magnitude exceeds 1.0 every wheel is scaled by 1.0/peak, truncated toward zero,
// so the largest becomes exactly 1.0; the right-hand wheels are then negated for mounting.
// one beat is accepted every cycle while the output is not stalled; the pipeline is made of
// three front stages (sums, magnitudes, peak), one divider stage per quotient bit and the
// output register. a stall on the master side holds the whole pipeline in place.
module mecanum_wheel_mixer_top
    import mwm_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // forward_speed [15:0], turn_rate [31:16], strafe_speed [47:32]
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // fl wheel drive [14:0], fr wheel drive [29:15], rl wheel drive [44:30],
    // rr wheel drive [59:45], zero fill above
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready
);

    // whole pipeline moves when the output slot is free or being emptied
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // stage 1: wheel sums
    logic     valid1_reg;
    sum_vec_t sum1_reg;
    sum_vec_t sum1_next;

    always_comb begin
        logic signed [SUM_W-1:0] v;
        logic signed [SUM_W-1:0] w;
        logic signed [SUM_W-1:0] s;
        v = SUM_W'(signed'(s_tdata[IN_W-1:0]));
        w = SUM_W'(signed'(s_tdata[2*IN_W-1:IN_W]));
        s = SUM_W'(signed'(s_tdata[3*IN_W-1:2*IN_W]));
        sum1_next[LANE_FL] = v - w + s;
        sum1_next[LANE_FR] = v + w - s;
        sum1_next[LANE_RL] = v - w - s;
        sum1_next[LANE_RR] = v + w + s;
    end

    // stage 2: magnitudes and signs
    logic     valid2_reg;
    mag_vec_t mag2_reg;
    mag_vec_t mag2_next;
    side_t    side2_reg;
    side_t    side2_next;

    always_comb begin
        side2_next       = '0;
        side2_next.wheel = sum1_reg;
        for (int i = 0; i < LANES; i++) begin
            side2_next.neg[i] = sum1_reg[i][SUM_W-1];
            mag2_next[i] = sum1_reg[i][SUM_W-1] ? MAG_W'(-sum1_reg[i])
                                                : MAG_W'(sum1_reg[i]);
        end
    end

    // stage 3: peak magnitude and scale decision
    logic             valid3_reg;
    logic [MAG_W-1:0] peak3_reg;
    logic [MAG_W-1:0] peak3_next;
    mag_vec_t         mag3_reg;
    side_t            side3_reg;
    side_t            side3_next;

    always_comb begin
        logic [MAG_W-1:0] max_a;
        logic [MAG_W-1:0] max_b;
        max_a = (mag2_reg[LANE_FL] > mag2_reg[LANE_FR]) ? mag2_reg[LANE_FL]
                                                        : mag2_reg[LANE_FR];
        max_b = (mag2_reg[LANE_RL] > mag2_reg[LANE_RR]) ? mag2_reg[LANE_RL]
                                                        : mag2_reg[LANE_RR];
        peak3_next       = (max_a > max_b) ? max_a : max_b;
        side3_next       = side2_reg;
        side3_next.scale = (32'(peak3_next) > ONE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
        end else if (en) begin
            valid1_reg <= s_tvalid;
            valid2_reg <= valid1_reg;
            valid3_reg <= valid2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum1_reg  <= sum1_next;
            mag2_reg  <= mag2_next;
            side2_reg <= side2_next;
            peak3_reg <= peak3_next;
            mag3_reg  <= mag2_reg;
            side3_reg <= side3_next;
        end
    end

    // divider: |wheel| * 1.0 / peak, one quotient bit per stage
    logic     div_valid;
    quo_vec_t div_quo;
    side_t    div_side;

    mwm_divider u_divider (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (valid3_reg),
        .in_divisor  (peak3_reg),
        .in_dividend (mag3_reg),
        .in_side     (side3_reg),
        .out_valid   (div_valid),
        .out_quo     (div_quo),
        .out_side    (div_side)
    );

    // output stage: restore sign, pick scaled or raw, negate right side
    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_next;

    always_comb begin
        logic signed [VAL_W-1:0] mag_s;
        logic signed [VAL_W-1:0] val;
        m_tdata_next = '0;
        for (int i = 0; i < LANES; i++) begin
            mag_s = VAL_W'(signed'({1'b0, div_quo[i]}));
            if (div_side.scale) begin
                val = div_side.neg[i] ? -mag_s : mag_s;
            end else begin
                val = VAL_W'(signed'(div_side.wheel[i]));
            end
            // right-hand wheels are mounted mirrored
            if (i == LANE_FR || i == LANE_RR) begin
                val = -val;
            end
            m_tdata_next[i*OUT_W +: OUT_W] = val[OUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire
